@@ hdl/pip_pkg.sv @@
package pip_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = 2 * DiffW;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTestX = 2'd0,
    CfgTestY = 2'd1
  } cfg_reg_e;

  // Endpoints of one edge plus its crossing qualifiers
  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic                     en;
    logic                     a1;
  } edge_ops_t;

  // Stage advance strobes for the edge datapath
  typedef struct packed {
    logic ld_diff;
    logic ld_prod;
  } edge_ctrl_t;

endpackage

@@ hdl/pip_if.sv @@
interface pip_cfg_if;
  import pip_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CfgIdxW-1:0]       reg_index;
  logic signed [CoordW-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

interface pip_vertex_if;
  import pip_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] vertex_x;
  logic signed [CoordW-1:0] vertex_y;
  logic                     contour_start;
  logic                     polygon_end;

  modport source (output valid, output vertex_x, output vertex_y,
                  output contour_start, output polygon_end, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y,
                  input contour_start, input polygon_end, output ready);
endinterface

interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

@@ hdl/pip_edge_test.sv @@
module pip_edge_test (
  input  logic                             clk_i,
  input  pip_pkg::edge_ctrl_t              ctrl_i,
  input  pip_pkg::edge_ops_t               ops_i,
  input  logic signed [pip_pkg::CoordW-1:0] test_x_i,
  input  logic signed [pip_pkg::CoordW-1:0] test_y_i,
  output logic                             toggle_o
);
  import pip_pkg::*;

  typedef struct packed {
    logic signed [DiffW-1:0] dy1;
    logic signed [DiffW-1:0] dx0;
    logic signed [DiffW-1:0] dx1;
    logic signed [DiffW-1:0] dy0;
    logic                    en;
    logic                    a1;
  } edge_diff_t;

  edge_diff_t              diff_d, diff_q;
  logic signed [ProdW-1:0] lhs_d, lhs_q;
  logic signed [ProdW-1:0] rhs_d, rhs_q;
  logic                    en_q, a1_q;

  // Exact differences, one bit wider than the coordinates
  always_comb begin
    diff_d.dy1 = DiffW'(ops_i.y1) - DiffW'(test_y_i);
    diff_d.dx0 = DiffW'(ops_i.x0) - DiffW'(ops_i.x1);
    diff_d.dx1 = DiffW'(ops_i.x1) - DiffW'(test_x_i);
    diff_d.dy0 = DiffW'(ops_i.y0) - DiffW'(ops_i.y1);
    diff_d.en  = ops_i.en;
    diff_d.a1  = ops_i.a1;
  end

  assign lhs_d = diff_q.dy1 * diff_q.dx0;
  assign rhs_d = diff_q.dx1 * diff_q.dy0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_diff) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.ld_prod) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
      en_q  <= diff_q.en;
      a1_q  <= diff_q.a1;
    end
  end

  assign toggle_o = en_q && ((lhs_q >= rhs_q) == a1_q);

endmodule

@@ hdl/point_in_polygon_crossing_test.sv @@
// Channel   | Dir | Payload                                           | Transfer when
// cfg_i     | in  | reg_index, reg_data (test_x = 0, test_y = 1)      | valid && ready
// vertex_i  | in  | vertex_x, vertex_y, contour_start, polygon_end    | valid && ready
// result_o  | out | inside_res (one per polygon, on polygon_end)      | valid && ready
//
// One vertex a cycle while vertex_i.ready is high. A result is valid once its polygon_end vertex has passed the
// input register, difference stage, multiply stage (four 33x33 multipliers, two per edge),
// then compare and parity feeding the result register.
// Reset (rst_ni low) clears the test point, the open-contour and parity state and
// all stage valids.
// A stalled result holds only the compare stage when it carries a polygon end; earlier
// stages keep filling, so vertices are still taken until the input, difference and
// multiply stages are all full.
module point_in_polygon_crossing_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  pip_cfg_if.sink             cfg_i,
  pip_vertex_if.sink          vertex_i,
  pip_result_if.source        result_o
);
  import pip_pkg::*;

  // Configuration
  logic signed [CoordW-1:0] test_x_q, test_y_q;

  // Contour tracking
  logic signed [CoordW-1:0] first_x_q, first_y_q;
  logic signed [CoordW-1:0] prev_x_q, prev_y_q;
  logic                     prev_above_q;
  logic                     open_q;

  // Pipeline control
  logic      s1_v_q, s1_end_q;
  edge_ops_t s1_edge_a_q, s1_edge_b_q;
  logic      s2_v_q, s2_end_q;
  logic      s3_v_q, s3_end_q;
  logic      out_v_q, inside_q;
  logic      parity_q;

  logic       out_free, s3_go, s3_free, s2_free, s1_free, in_xfer;
  logic       new_contour, v_above, first_above;
  edge_ops_t  edge_a, edge_b;
  edge_ctrl_t edge_ctrl;
  logic       tog_a, tog_b, tog;

  // Configuration writes: always ready, drop unknown indexes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_x_q <= '0;
      test_y_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.reg_index))
        CfgTestX: test_x_q <= cfg_i.reg_data;
        CfgTestY: test_y_q <= cfg_i.reg_data;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage may load when it is empty or passing its item on
  assign out_free = !out_v_q || result_o.ready;
  assign s3_go    = s3_v_q && (!s3_end_q || out_free);
  assign s3_free  = !s3_v_q || s3_go;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_free  = !s1_v_q || s2_free;

  assign vertex_i.ready = s1_free;
  assign in_xfer        = vertex_i.valid && s1_free;

  // Edge selection. A vertex with no contour open starts one, as does contour_start.
  // Edge A: previous vertex to this one, or the old contour's closing edge.
  // Edge B: this vertex back to the first one when the polygon ends mid-contour.
  assign new_contour = vertex_i.contour_start || !open_q;
  assign v_above     = vertex_i.vertex_y >= test_y_q;
  assign first_above = first_y_q >= test_y_q;

  always_comb begin
    edge_a.x0 = prev_x_q;
    edge_a.y0 = prev_y_q;
    edge_a.x1 = new_contour ? first_x_q : vertex_i.vertex_x;
    edge_a.y1 = new_contour ? first_y_q : vertex_i.vertex_y;
    edge_a.a1 = new_contour ? first_above : v_above;
    edge_a.en = open_q && (edge_a.a1 != prev_above_q);

    // A one-vertex contour closes on itself and never crosses
    edge_b.x0 = vertex_i.vertex_x;
    edge_b.y0 = vertex_i.vertex_y;
    edge_b.x1 = first_x_q;
    edge_b.y1 = first_y_q;
    edge_b.a1 = first_above;
    edge_b.en = vertex_i.polygon_end && !new_contour && (first_above != v_above);
  end

  // Contour state advances at each vertex transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      prev_above_q <= 1'b0;
    end else if (in_xfer) begin
      open_q       <= !vertex_i.polygon_end;
      prev_above_q <= !vertex_i.polygon_end && v_above;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      prev_x_q <= vertex_i.vertex_x;
      prev_y_q <= vertex_i.vertex_y;
      if (new_contour) begin
        first_x_q <= vertex_i.vertex_x;
        first_y_q <= vertex_i.vertex_y;
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= vertex_i.valid;
      if (s2_free) s2_v_q <= s1_v_q;
      if (s3_free) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_end_q    <= vertex_i.polygon_end;
      s1_edge_a_q <= edge_a;
      s1_edge_b_q <= edge_b;
    end
    if (s2_free) s2_end_q <= s1_end_q;
    if (s3_free) s3_end_q <= s2_end_q;
  end

  assign edge_ctrl.ld_diff = s2_free;
  assign edge_ctrl.ld_prod = s3_free;

  pip_edge_test u_edge_a (
    .clk_i    (clk_i),
    .ctrl_i   (edge_ctrl),
    .ops_i    (s1_edge_a_q),
    .test_x_i (test_x_q),
    .test_y_i (test_y_q),
    .toggle_o (tog_a)
  );

  pip_edge_test u_edge_b (
    .clk_i    (clk_i),
    .ctrl_i   (edge_ctrl),
    .ops_i    (s1_edge_b_q),
    .test_x_i (test_x_q),
    .test_y_i (test_y_q),
    .toggle_o (tog_b)
  );

  assign tog = tog_a ^ tog_b;

  // Parity accumulates in vertex order; a polygon end emits it and clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (s3_go) begin
        parity_q <= s3_end_q ? 1'b0 : (parity_q ^ tog);
      end
      if (s3_go && s3_end_q) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_go && s3_end_q) begin
      inside_q <= parity_q ^ tog;
    end
  end

  assign result_o.valid      = out_v_q;
  assign result_o.inside_res = inside_q;

`ifndef SYNTHESIS
  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s3_v_q && s3_end_q))
    else $error("result raised without a polygon end in the compare stage");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && vertex_i.polygon_end) |=> (!open_q && !prev_above_q))
    else $error("contour state not cleared after polygon end");

  a_vertex_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !vertex_i.polygon_end) |=> open_q)
    else $error("contour not open after a vertex transfer");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vertex_i.ready |-> (s1_v_q && s2_v_q && s3_v_q && s3_end_q && out_v_q))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
